// ===== hdl/stftps_pkg.sv =====
// ----------------------------------------------------------------------------
// STFT power spectrogram package
// Shared sizes, control structs and elaboration-time sine, cosine and window
// coefficient generators.
// ----------------------------------------------------------------------------
package stftps_pkg;

  localparam int WinLen     = 16;
  localparam int SampleBits = 16;
  localparam int NBins      = 2 * WinLen - 1;
  localparam int HamDen     = WinLen - 1;
  localparam int AccBits    = 36;
  localparam int RndBits    = AccBits - SampleBits + 1;
  localparam int PowBits    = 40;

  localparam longint unsigned OneQ30 = 64'd1 << 30;
  localparam longint unsigned Pi4Q30 = 64'd843314857;

  typedef struct packed {
    logic shift;
    logic load;
    logic rot;
  } cell_ctl_t;

  typedef struct packed {
    logic clr;
    logic acc;
  } mac_ctl_t;

  function automatic longint taylor_sin(input longint unsigned a);
    longint unsigned a2;
    longint unsigned term;
    longint sum;
    a2   = (a * a) >> 30;
    term = a;
    sum  = longint'(a);
    term = ((term * a2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 72;
    sum  = sum + longint'(term);
    return sum;
  endfunction

  function automatic longint taylor_cos(input longint unsigned a);
    longint unsigned a2;
    longint unsigned term;
    longint sum;
    a2   = (a * a) >> 30;
    term = OneQ30;
    sum  = longint'(OneQ30);
    term = ((term * a2) >> 30) / 2;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 12;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 30;
    sum  = sum - longint'(term);
    term = ((term * a2) >> 30) / 56;
    sum  = sum + longint'(term);
    term = ((term * a2) >> 30) / 90;
    sum  = sum - longint'(term);
    return sum;
  endfunction

  // Octant fold: returns sine when want_sin is set, cosine otherwise.
  function automatic longint sc_core(input int unsigned oct, input longint unsigned ang,
                                     input logic want_sin);
    longint ps;
    longint pc;
    longint s;
    longint c;
    if (oct % 2 == 1) begin
      ps = taylor_cos(ang);
      pc = taylor_sin(ang);
    end else begin
      ps = taylor_sin(ang);
      pc = taylor_cos(ang);
    end
    case ((oct / 2) % 4)
      0: begin s = ps;  c = pc;  end
      1: begin s = pc;  c = -ps; end
      2: begin s = -ps; c = -pc; end
      default: begin s = -pc; c = ps; end
    endcase
    return want_sin ? s : c;
  endfunction

  function automatic longint tw_q30(input int unsigned m, input logic want_sin);
    int unsigned oct;
    int unsigned r;
    longint unsigned ang;
    oct = (8 * (m % NBins)) / NBins;
    r   = (8 * (m % NBins)) % NBins;
    if (oct % 2 == 1) ang = Pi4Q30 * longint'(NBins - r) / NBins;
    else ang = Pi4Q30 * longint'(r) / NBins;
    return sc_core(oct, ang, want_sin);
  endfunction

  function automatic logic signed [15:0] q30_to_q15(input longint v);
    longint unsigned mag;
    longint unsigned q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q   = (mag + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return (v < 0) ? -16'(q) : 16'(q);
  endfunction

  function automatic logic signed [15:0] tw_cos(input int unsigned m);
    return q30_to_q15(tw_q30(m, 1'b0));
  endfunction

  function automatic logic signed [15:0] tw_sin(input int unsigned m);
    return q30_to_q15(tw_q30(m, 1'b1));
  endfunction

  function automatic logic [15:0] ham_coef(input int unsigned n);
    int unsigned oct;
    int unsigned r;
    longint unsigned ang;
    longint c;
    longint unsigned num;
    longint unsigned w;
    oct = (8 * (n % HamDen)) / HamDen;
    r   = (8 * (n % HamDen)) % HamDen;
    if (oct % 2 == 1) ang = Pi4Q30 * longint'(HamDen - r) / HamDen;
    else ang = Pi4Q30 * longint'(r) / HamDen;
    c   = sc_core(oct, ang, 1'b0);
    num = longint'(54 * longint'(OneQ30) - 46 * c);
    w   = (num + 64'd819200) / 64'd1638400;
    if (w > 64'd65535) w = 64'd65535;
    return 16'(w);
  endfunction

endpackage

// ===== hdl/stft_power_spectrogram.sv =====
// ----------------------------------------------------------------------------
// STFT power spectrogram
// Hamming-windowed, zero-padded 31-point DFT power over a 16-sample window.
// ----------------------------------------------------------------------------
// A sample request is taken only while the block is idle. When it completes a frame (the first
// full window, then every hop_size samples), the block stops taking samples
// and produces 31 bin requests in order, each one waiting out any output stall:
// a row of cells rotates the windowed frame past a single multiply-accumulate
// unit, one sample per cycle.
module stft_power_spectrogram import stftps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [4:0]          bin_index_o,
  output logic [PowBits-1:0]  power_o,
  output logic                last_bin_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StLoad = 4'b0010,
    StMac  = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [4:0]  hop_size_q;
  logic [4:0]  fill_q, hop_q;
  logic [4:0]  hop_inc;
  logic [3:0]  t_q;
  logic [4:0]  k_q;
  logic        out_valid_q;
  logic [4:0]  bin_q;
  logic [PowBits-1:0] power_q;
  logic        last_q;
  logic        accept, emit, out_free;
  logic [PowBits-1:0] mac_power;
  cell_ctl_t   cell_ctl;
  mac_ctl_t    mac_ctl;

  logic signed [SampleBits-1:0] samp_w [WinLen];
  logic signed [SampleBits-1:0] xw_w [WinLen];

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign hop_inc  = hop_q + 5'd1;
  assign emit     = (fill_q < 5'(WinLen)) ? (fill_q == 5'(WinLen - 1))
                                          : (hop_inc >= hop_size_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept && emit) state_d = StLoad;
      StLoad: state_d = StMac;
      StMac:  if (t_q == 4'(WinLen - 1)) state_d = StEmit;
      StEmit: begin
        if (out_free) state_d = (k_q == 5'(NBins - 1)) ? StIdle : StMac;
      end
      default: state_d = StIdle;
    endcase
  end

  assign cell_ctl.shift = accept;
  assign cell_ctl.load  = (state_q == StLoad);
  assign cell_ctl.rot   = (state_q == StMac);
  assign mac_ctl.clr    = (state_q == StLoad) || (state_q == StEmit && out_free);
  assign mac_ctl.acc    = (state_q == StMac);

  for (genvar g = 0; g < WinLen; g++) begin : g_cell
    stftps_cell #(.T(g)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .samp_i ((g == WinLen - 1) ? sample_i : samp_w[(g + 1) % WinLen]),
      .samp_o (samp_w[g]),
      .xw_i   (xw_w[(g + 1) % WinLen]),
      .xw_o   (xw_w[g])
    );
  end

  stftps_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .k_i     (k_q),
    .xw_i    (xw_w[0]),
    .power_o (mac_power)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      hop_size_q  <= 5'd8;
      fill_q      <= '0;
      hop_q       <= '0;
      t_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) hop_size_q <= cfg_wdata_i;
      if (accept) begin
        if (fill_q < 5'(WinLen)) begin
          fill_q <= fill_q + 5'd1;
          if (emit) hop_q <= '0;
        end else begin
          hop_q <= emit ? 5'd0 : hop_inc;
        end
      end
      if (state_q == StLoad) begin
        t_q <= '0;
        k_q <= '0;
      end else if (state_q == StMac) begin
        t_q <= t_q + 4'd1;
      end else if (state_q == StEmit && out_free) begin
        k_q <= k_q + 5'd1;
      end
      if (state_q == StEmit && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StEmit && out_free) begin
      bin_q   <= k_q;
      power_q <= mac_power;
      last_q  <= (k_q == 5'(NBins - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = bin_q;
  assign power_o     = power_q;
  assign last_bin_o  = last_q;

endmodule

// ===== hdl/stftps_cell.sv =====
// ----------------------------------------------------------------------------
// STFT window cell
// Holds one sample of the history and one windowed frame value, both handed
// along the row to the neighbor.
// ----------------------------------------------------------------------------
module stftps_cell import stftps_pkg::*; #(
  parameter int T = 0
) (
  input  logic                         clk_i,
  input  cell_ctl_t                    ctl_i,
  input  logic signed [SampleBits-1:0] samp_i,
  output logic signed [SampleBits-1:0] samp_o,
  input  logic signed [SampleBits-1:0] xw_i,
  output logic signed [SampleBits-1:0] xw_o
);

  localparam logic [15:0] Coef = ham_coef(T);

  logic signed [SampleBits-1:0] samp_q;
  logic signed [SampleBits-1:0] xw_q;
  logic signed [SampleBits+17:0] prod;
  logic signed [SampleBits+17:0] prod_r;

  assign prod   = samp_q * $signed({1'b0, Coef});
  assign prod_r = (prod + (SampleBits+18)'(32768)) >>> 16;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) samp_q <= samp_i;
    if (ctl_i.load) xw_q <= prod_r[SampleBits-1:0];
    else if (ctl_i.rot) xw_q <= xw_i;
  end

  assign samp_o = samp_q;
  assign xw_o   = xw_q;

endmodule

// ===== hdl/stftps_mac.sv =====
// ----------------------------------------------------------------------------
// STFT bin accumulator
// Multiplies the frame head by the twiddle for the current bin and sums real
// and imaginary parts, then forms the saturated squared magnitude.
// ----------------------------------------------------------------------------
module stftps_mac import stftps_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mac_ctl_t                     ctl_i,
  input  logic [4:0]                   k_i,
  input  logic signed [SampleBits-1:0] xw_i,
  output logic [PowBits-1:0]           power_o
);

  logic signed [15:0] cos_tab [NBins];
  logic signed [15:0] sin_tab [NBins];

  for (genvar g = 0; g < NBins; g++) begin : g_tab
    assign cos_tab[g] = tw_cos(g);
    assign sin_tab[g] = tw_sin(g);
  end

  logic [4:0]                j_q, j_d;
  logic [5:0]                j_sum;
  logic signed [AccBits-1:0] re_q, re_d, im_q, im_d;
  logic signed [RndBits-1:0] r15, i15;
  logic signed [AccBits-1:0] re_h, im_h;
  logic [2*RndBits-1:0]      rsq, isq;
  logic [2*RndBits:0]        psum;

  assign j_sum = {1'b0, j_q} + {1'b0, k_i};

  always_comb begin
    j_d  = j_q;
    re_d = re_q;
    im_d = im_q;
    if (ctl_i.clr) begin
      j_d  = '0;
      re_d = '0;
      im_d = '0;
    end else if (ctl_i.acc) begin
      j_d  = (j_sum >= 6'(NBins)) ? 5'(j_sum - 6'(NBins)) : j_sum[4:0];
      re_d = re_q + AccBits'(xw_i * cos_tab[j_q]);
      im_d = im_q - AccBits'(xw_i * sin_tab[j_q]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else begin
      j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
  end

  assign re_h = (re_q + AccBits'(1 << (SampleBits-2))) >>> (SampleBits-1);
  assign im_h = (im_q + AccBits'(1 << (SampleBits-2))) >>> (SampleBits-1);
  assign r15  = re_h[RndBits-1:0];
  assign i15  = im_h[RndBits-1:0];
  assign rsq  = unsigned'((2*RndBits)'(r15 * r15));
  assign isq  = unsigned'((2*RndBits)'(i15 * i15));
  assign psum = {1'b0, rsq} + {1'b0, isq};

  assign power_o = (psum > (2*RndBits+1)'({PowBits{1'b1}})) ? {PowBits{1'b1}}
                                                           : psum[PowBits-1:0];

endmodule

// ===== tb/stft_power_spectrogram_tb.sv =====
// ----------------------------------------------------------------------------
// STFT power spectrogram testbench
// Drives signed samples through the valid/stall request channel, predicts
// every bin power of each Hamming-windowed frame in a scoreboard and checks
// the bin requests in order while the hop size is changed between phases.
// ----------------------------------------------------------------------------
module stft_power_spectrogram_tb;
  import stftps_pkg::*;

  localparam int NumTaps = 16;
  localparam int NumFreq = 31;
  localparam longint unsigned PowSat = 64'hFF_FFFF_FFFF;
  localparam longint unsigned Pi4 = 64'd843314857;
  localparam longint Unit = 64'sd1 << 30;

  typedef struct packed {
    logic [4:0]  bin;
    logic [39:0] pwr;
    logic        last;
  } bin_res_t;

  function automatic longint sin_series(input longint unsigned a);
    longint unsigned a2, t;
    longint acc;
    a2 = (a * a) >> 30;
    t = a;
    acc = longint'(a);
    for (int n = 1; n <= 4; n++) begin
      t = ((t * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
      acc = (n % 2) ? acc - longint'(t) : acc + longint'(t);
    end
    return acc;
  endfunction

  function automatic longint cos_series(input longint unsigned a);
    longint unsigned a2, t;
    longint acc;
    a2 = (a * a) >> 30;
    t = Unit;
    acc = Unit;
    for (int n = 1; n <= 5; n++) begin
      t = ((t * a2) >> 30) / longint'((2 * n - 1) * (2 * n));
      acc = (n % 2) ? acc - longint'(t) : acc + longint'(t);
    end
    return acc;
  endfunction

  function automatic void angle_q30(input int m, input int den, output longint s,
                                    output longint c);
    int mm, oc, r;
    longint ps, pc;
    longint unsigned a;
    mm = m % den;
    oc = (8 * mm) / den;
    r = (8 * mm) % den;
    if (oc % 2) begin
      a = Pi4 * longint'(den - r) / den;
      ps = cos_series(a);
      pc = sin_series(a);
    end else begin
      a = Pi4 * longint'(r) / den;
      ps = sin_series(a);
      pc = cos_series(a);
    end
    case ((oc / 2) % 4)
      0: begin s = ps; c = pc; end
      1: begin s = pc; c = -ps; end
      2: begin s = -ps; c = -pc; end
      default: begin s = -pc; c = ps; end
    endcase
  endfunction

  function automatic longint round_q15(input longint v);
    longint q;
    q = ((v < 0 ? -v : v) + 16384) >>> 15;
    if (q > 32767) q = 32767;
    return v < 0 ? -q : q;
  endfunction

  class spectrum_scoreboard;
    longint cos_tab[NumFreq];
    longint sin_tab[NumFreq];
    longint win_tab[NumTaps];
    logic signed [15:0] history[NumTaps];
    int wr_ptr, filled, hop_cnt, hop_len, errors;
    bin_res_t pending[$];

    function new();
      longint s, c;
      longint unsigned w;
      for (int j = 0; j < NumFreq; j++) begin
        angle_q30(j, NumFreq, s, c);
        cos_tab[j] = round_q15(c);
        sin_tab[j] = round_q15(s);
      end
      for (int n = 0; n < NumTaps; n++) begin
        angle_q30(n, NumTaps - 1, s, c);
        w = (longint'(54 * Unit - 46 * c) + 64'd819200) / 64'd1638400;
        win_tab[n] = (w > 65535) ? 65535 : longint'(w);
      end
      for (int n = 0; n < NumTaps; n++) history[n] = '0;
      wr_ptr = 0;
      filled = 0;
      hop_cnt = 0;
      hop_len = 8;
      errors = 0;
    endfunction

    function void note_sample(input logic signed [15:0] x);
      longint xw[NumTaps];
      longint re, im, r15, i15;
      longint unsigned p;
      bit fire;
      bin_res_t e;
      fire = 0;
      history[wr_ptr] = x;
      wr_ptr = (wr_ptr + 1) % NumTaps;
      if (filled < NumTaps) begin
        filled++;
        if (filled == NumTaps) begin
          fire = 1;
          hop_cnt = 0;
        end
      end else begin
        hop_cnt = (hop_cnt + 1) % 32;
        if (hop_cnt >= hop_len) begin
          fire = 1;
          hop_cnt = 0;
        end
      end
      if (!fire) return;
      for (int t = 0; t < NumTaps; t++)
        xw[t] = (longint'(history[(wr_ptr + t) % NumTaps]) * win_tab[t] + 32768) >>> 16;
      for (int k = 0; k < NumFreq; k++) begin
        re = 0;
        im = 0;
        for (int t = 0; t < NumTaps; t++) begin
          re += xw[t] * cos_tab[(k * t) % NumFreq];
          im -= xw[t] * sin_tab[(k * t) % NumFreq];
        end
        r15 = (re + 16384) >>> 15;
        i15 = (im + 16384) >>> 15;
        p = longint'(r15 * r15) + longint'(i15 * i15);
        if (p > PowSat) p = PowSat;
        e.bin = 5'(k);
        e.pwr = 40'(p);
        e.last = (k == NumFreq - 1);
        pending = {pending, e};
      end
    endfunction

    function void check_bin(input bin_res_t got);
      bin_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected bin request, actual %0d/%0d/%0d", $time, got.bin,
                 got.pwr, got.last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.bin !== e.bin) begin
        $display("%0t: bin_index expected %0d actual %0d", $time, e.bin, got.bin);
        errors++;
      end
      if (got.pwr !== e.pwr) begin
        $display("%0t: power expected %0d actual %0d", $time, e.pwr, got.pwr);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last_bin expected %0d actual %0d", $time, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i, in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [4:0] cfg_wdata_i, bin_index_o;
  logic signed [15:0] sample_i;
  logic [PowBits-1:0] power_o;
  logic last_bin_o;
  spectrum_scoreboard sb;
  bit calm;
  longint cycles;

  stft_power_spectrogram u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .sample_i(sample_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .bin_index_o(bin_index_o),
    .power_o(power_o), .last_bin_o(last_bin_o)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 64'd3_000_000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_bin('{bin: bin_index_o, pwr: power_o, last: last_bin_o});
  end

  initial begin
    int gap;
    out_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        out_stall_i = 1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 0;
    end
  end

  task automatic send_sample(input logic signed [15:0] x);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 11)) @(negedge clk_i);
    in_valid_i = 1;
    sample_i = x;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(x);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic set_hop(input logic [4:0] h);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    cfg_we_i = 1;
    cfg_wdata_i = h;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.hop_len = h;
  endtask

  task automatic random_run(input int n);
    logic signed [15:0] x;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        1: x = 16'($signed($urandom_range(0, 2047)) - 1024);
        default: x = 16'($urandom);
      endcase
      send_sample(x);
    end
  endtask

  initial begin
    logic [4:0] hops[8];
    sb = new();
    calm = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = '0;
    in_valid_i = 0;
    sample_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    for (int i = 0; i < 16; i++) send_sample(i == 0 ? 16'sh7FFF : 16'sh0000);
    for (int i = 0; i < 8; i++) send_sample(i % 2 ? 16'sh8000 : 16'sh7FFF);
    hops = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd1, 5'd7, 5'd16};
    foreach (hops[h]) begin
      set_hop(hops[h]);
      random_run(h == 1 ? 20 : 50);
    end
    calm = 1;
    random_run(20);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/stftps_pkg.sv
hdl/stftps_cell.sv
hdl/stftps_mac.sv
hdl/stft_power_spectrogram.sv
tb/stft_power_spectrogram_tb.sv
